// ----- sv/sorted_set_intersect_below_bound_assert.svh -----
// Assertion macros for the sorted-set intersection RTL.
// Needs nothing else; included by ssib_walk, the module that carries assertions.
`ifndef SORTED_SET_INTERSECT_BELOW_BOUND_ASSERT_SVH
`define SORTED_SET_INTERSECT_BELOW_BOUND_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define SSIB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked while out of reset.
`define SSIB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/ssib_pkg.sv -----
// Shared types and constants for the sorted-set intersection block.
// No dependencies; imported by the walk, output register and top modules.
package ssib_pkg;

  localparam int VALUE_W     = 32;
  localparam int TOTAL_W     = 11;
  localparam int OP_W        = 2;
  localparam int OUT_TDATA_W = 48;

  typedef enum logic [OP_W-1:0] {
    OP_BEGIN  = 2'd0,
    OP_APPEND = 2'd1,
    OP_PROBE  = 2'd2
  } op_e;

  typedef enum logic {
    KIND_MATCH = 1'b0,
    KIND_DONE  = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [VALUE_W-1:0] match_value;
    logic [TOTAL_W-1:0] match_total;
    logic               final_res;
  } res_t;

endpackage

// ----- sv/ssib_bstore.sv -----
// Synchronous single-port-write, single-port-read memory holding list B.
// Read data is registered. No package dependencies.
module ssib_bstore #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- sv/ssib_walk.sv -----
// Control for the intersection: command decode, list B bookkeeping and the
// merge walk over the B memory. Depends on ssib_pkg and the assertion header.
`include "sorted_set_intersect_below_bound_assert.svh"

module ssib_walk #(
  parameter int DEPTH = 1024,
  parameter int VW    = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  ssib_pkg::op_e          in_op_i,
  input  logic [VW-1:0]          in_value_i,
  input  logic                   in_last_i,
  output logic                   wr_en_o,
  output logic [AW-1:0]          wr_addr_o,
  output logic [VW-1:0]          wr_data_o,
  output logic                   rd_en_o,
  output logic [AW-1:0]          rd_addr_o,
  input  logic [VW-1:0]          rd_data_i,
  output logic                   res_valid_o,
  input  logic                   res_ready_i,
  output ssib_pkg::res_t         res_o
);
  import ssib_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_MATCH,
    ST_DONE
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [CW-1:0] found_q, found_d;
  logic [VW-1:0] bound_q, bound_d;
  logic          stopped_q, stopped_d;
  logic [VW-1:0] probe_q;
  logic          last_q;

  logic          accept;
  logic [CW-1:0] pos_inc;
  logic [CW+TOTAL_W-1:0] total_ext;
  logic [VW+VALUE_W-1:0] value_ext;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign pos_inc    = pos_q + 1'b1;

  assign wr_en_o   = accept && (in_op_i == OP_APPEND) && (count_q < CW'(DEPTH));
  assign wr_addr_o = count_q[AW-1:0];
  assign wr_data_o = in_value_i;

  assign total_ext = {{TOTAL_W{1'b0}}, found_q};
  assign value_ext = {{VALUE_W{1'b0}}, probe_q};

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pos_d       = pos_q;
    found_d     = found_q;
    bound_d     = bound_q;
    stopped_d   = stopped_q;
    rd_en_o     = 1'b0;
    rd_addr_o   = pos_q[AW-1:0];
    res_valid_o = 1'b0;
    res_o       = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_op_i)
            OP_BEGIN: begin
              bound_d   = in_value_i;
              count_d   = '0;
              pos_d     = '0;
              found_d   = '0;
              stopped_d = 1'b0;
            end
            OP_APPEND: begin
              if (count_q < CW'(DEPTH)) begin
                count_d = count_q + 1'b1;
              end
            end
            OP_PROBE: begin
              state_d = in_last_i ? ST_DONE : ST_IDLE;
              if (!stopped_q) begin
                if (in_value_i >= bound_q) begin
                  stopped_d = 1'b1;
                end else if (pos_q < count_q) begin
                  // Fetch the entry at the merge position; compared next cycle.
                  rd_en_o = 1'b1;
                  state_d = ST_CMP;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_CMP: begin
        if (rd_data_i < probe_q) begin
          pos_d = pos_inc;
          if (pos_inc < count_q) begin
            // Skip ahead: read the following entry while this one is dropped.
            rd_en_o   = 1'b1;
            rd_addr_o = pos_inc[AW-1:0];
          end else begin
            state_d = last_q ? ST_DONE : ST_IDLE;
          end
        end else if (rd_data_i == probe_q) begin
          pos_d   = pos_inc;
          found_d = found_q + 1'b1;
          state_d = ST_MATCH;
        end else begin
          state_d = last_q ? ST_DONE : ST_IDLE;
        end
      end
      ST_MATCH: begin
        res_valid_o       = 1'b1;
        res_o.kind        = KIND_MATCH;
        res_o.match_value = value_ext[VALUE_W-1:0];
        res_o.match_total = total_ext[TOTAL_W-1:0];
        res_o.final_res   = 1'b0;
        if (res_ready_i) begin
          state_d = last_q ? ST_DONE : ST_IDLE;
        end
      end
      ST_DONE: begin
        res_valid_o       = 1'b1;
        res_o.kind        = KIND_DONE;
        res_o.match_value = '0;
        res_o.match_total = total_ext[TOTAL_W-1:0];
        res_o.final_res   = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      pos_q     <= '0;
      found_q   <= '0;
      bound_q   <= '0;
      stopped_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      pos_q     <= pos_d;
      found_q   <= found_d;
      bound_q   <= bound_d;
      stopped_q <= stopped_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      probe_q <= in_value_i;
      last_q  <= in_last_i;
    end
  end

  `SSIB_ASSERT_NOW(a_pos_in_list, clk_i, rst_ni, 1'b1, pos_q <= count_q, "merge position past list end")
  `SSIB_ASSERT_NOW(a_count_in_depth, clk_i, rst_ni, 1'b1, count_q <= CW'(DEPTH), "list count beyond depth")
  `SSIB_ASSERT_NOW(a_cmp_reads_valid, clk_i, rst_ni, state_q == ST_CMP, pos_q < count_q, "compare on an entry beyond the list")
  `SSIB_ASSERT_NOW(a_found_le_pos, clk_i, rst_ni, 1'b1, found_q <= pos_q, "more matches than consumed entries")

endmodule

// ----- sv/ssib_outreg.sv -----
// Output register for result transfers, so the walk can go idle and accept
// the next item while a result still waits. Depends on ssib_pkg.
module ssib_outreg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           res_valid_i,
  output logic           res_ready_o,
  input  ssib_pkg::res_t res_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ssib_pkg::res_t out_o
);
  import ssib_pkg::*;

  logic valid_q, valid_d;
  res_t data_q;

  assign res_ready_o = !valid_q || out_ready_i;
  assign valid_d     = res_valid_i || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i && res_ready_o) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = data_q;

endmodule

// ----- sv/sorted_set_intersect_below_bound.sv -----
// Channel  | Signals                        | Payload
// ---------+--------------------------------+----------------------------------------
// input    | s_axis_tvalid/tready/tdata/... | tdata: value; tuser: operation; tlast
// result   | m_axis_tvalid/tready/tdata/... | tdata: match_value, match_total;
//          |                                | tuser: kind; tlast: final_res
// Begin, append and probes that stop or find the list exhausted are handled
// as they are accepted. A probe that walks B reads its entries in turn through
// the single read port of the B memory, whose read data is registered,
// skipping entries below the probe until it meets a match, a larger entry or
// the end of B. Each result waits in the MATCH or DONE state until taken. Reset
// is asynchronous, active low, and needs no memory clearing. A stalled result
// holds in the output register while the next input item is taken.
module sorted_set_intersect_below_bound #(
  parameter int LIST_DEPTH = 1024,
  parameter int VALUE_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [ssib_pkg::VALUE_W-1:0]     s_axis_tdata,  // [31:0] value
  input  logic [ssib_pkg::OP_W-1:0]        s_axis_tuser,  // [1:0] operation
  input  logic                             s_axis_tlast,  // last
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [ssib_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // [31:0] match_value,
                                                          // [42:32] match_total
  output logic                             m_axis_tuser,  // [0] kind
  output logic                             m_axis_tlast   // final_res
);
  import ssib_pkg::*;

  localparam int VW = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
  localparam int AW = $clog2(LIST_DEPTH);

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [VW-1:0] wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [VW-1:0] rd_data;
  logic          res_valid;
  logic          res_ready;
  res_t          res;
  res_t          out_res;

  ssib_bstore #(
    .DEPTH (LIST_DEPTH),
    .WIDTH (VW)
  ) u_bstore (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  ssib_walk #(
    .DEPTH (LIST_DEPTH),
    .VW    (VW)
  ) u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (op_e'(s_axis_tuser)),
    .in_value_i  (s_axis_tdata[VW-1:0]),
    .in_last_i   (s_axis_tlast),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  ssib_outreg u_outreg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_i       (res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (out_res)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W - TOTAL_W - VALUE_W){1'b0}},
                         out_res.match_total, out_res.match_value};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.final_res;

endmodule
